// File: hdl/cadj_pkg.sv
// ----------------------------------------------------------------------------
// cadj_pkg
// shared types and constants of the rgb565 color adjust pipeline
// ----------------------------------------------------------------------------
package cadj_pkg;

    localparam int CH_W = 8;
    localparam int QB   = 17;            // quotient bits of the q16 dividers

    localparam logic [16:0] Q16_ONE        = 17'd65536;
    localparam logic [16:0] HUE_THIRD      = 17'd21845;
    localparam logic [16:0] HUE_SIXTH      = 17'd10923;
    localparam logic [16:0] HUE_HALF       = 17'd32768;
    localparam logic [16:0] HUE_TWO_THIRDS = 17'd43691;

    // floor(x/6) for x < 2^19 as (x * DIV6_MUL) >> 22
    localparam logic [19:0] DIV6_MUL = 20'd699051;

    localparam logic [10:0] SAT_UNITY   = 11'd256;
    localparam logic [10:0] SAT_RESET   = 11'd256;
    localparam logic [10:0] CGAIN_RESET = 11'd256;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_ADDR_W-1:0] REG_SATURATION = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMPERATURE = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TINT       = 8'd3;

    localparam logic CMD_TABLE_WRITE = 1'b0;
    localparam logic CMD_PIXEL       = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

endpackage

// File: hdl/rgb565_color_adjust_pipeline_unit.sv
// ----------------------------------------------------------------------------
// rgb565_color_adjust_pipeline_unit
// rgb565 pixel levels, saturation, contrast and white balance adjust
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  tdata: index, value, pixel; tuser: command
// m_       out  m_tvalid / m_tready  tdata: red, green, blue
// cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// one request per clock while the output is not stalled; a pixel passes through the
// levels read, the 17-step hsl dividers plus six hsl stages, and the tone stages
// table write requests update the table on acceptance and give no result
// one global enable: the whole pipeline holds while the output waits
// synchronous active-low reset clears valid bits, config registers and table marks
// ----------------------------------------------------------------------------
module rgb565_color_adjust_pipeline_unit
    import cadj_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // table_index, table_value, pixel_rgb565
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // red, green, blue
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [10:0]       sat_reg, cgain_reg;
    logic signed [9:0] temp_reg, tint_reg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg   <= SAT_RESET;
            cgain_reg <= CGAIN_RESET;
            temp_reg  <= '0;
            tint_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SATURATION:  sat_reg   <= cfg_wdata;
                REG_CONTRAST:    cgain_reg <= cfg_wdata;
                REG_TEMPERATURE: temp_reg  <= cfg_wdata[9:0];
                REG_TINT:        tint_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // stall: everything advances when the output slot is free or taken
    logic en, accept;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    logic lv_valid, hs_valid, tn_valid;
    rgb_t lv_rgb, hs_rgb, tn_rgb;

    cadj_levels u_levels (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .accept       (accept),
        .command      (s_tuser),
        .table_index  (s_tdata[7:0]),
        .table_value  (s_tdata[15:8]),
        .pixel_rgb565 (s_tdata[31:16]),
        .out_valid    (lv_valid),
        .out_rgb      (lv_rgb)
    );

    cadj_hsl u_hsl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (lv_valid),
        .in_rgb            (lv_rgb),
        .saturation_factor (sat_reg),
        .out_valid         (hs_valid),
        .out_rgb           (hs_rgb)
    );

    // last tone stage is the output register
    cadj_tone u_tone (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (hs_valid),
        .in_rgb        (hs_rgb),
        .contrast_gain (cgain_reg),
        .temperature   (temp_reg),
        .tint          (tint_reg),
        .out_valid     (tn_valid),
        .out_rgb       (tn_rgb)
    );

    assign m_tvalid = tn_valid;
    assign m_tdata  = {tn_rgb.b, tn_rgb.g, tn_rgb.r};

endmodule

// File: hdl/cadj_div.sv
// ----------------------------------------------------------------------------
// cadj_div
// pipelined restoring divider, floor(num * 2^16 / den) for num <= den
// ----------------------------------------------------------------------------
module cadj_div
    import cadj_pkg::*;
(
    input  logic          aclk,
    input  logic          en,
    input  logic [8:0]    num,
    input  logic [8:0]    den,
    output logic [QB-1:0] quo
);

    logic [8:0]    rem_reg [QB];
    logic [8:0]    dv_reg  [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [9:0]    trial;
        logic [8:0]    dv_in;
        logic [QB-1:0] quo_in;
        logic          take;
        logic [8:0]    rem_next;

        if (k == 0) begin : g_first
            assign trial  = {1'b0, num};
            assign dv_in  = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign trial  = {rem_reg[k-1], 1'b0};
            assign dv_in  = dv_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign take     = (trial >= {1'b0, dv_in});
        assign rem_next = take ? 9'(trial - {1'b0, dv_in}) : trial[8:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                dv_reg[k]  <= dv_in;
                quo_reg[k] <= {quo_in[QB-2:0], take};
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

// File: hdl/cadj_levels.sv
// ----------------------------------------------------------------------------
// cadj_levels
// rgb565 widening and per-channel levels lookup, table writes
// ----------------------------------------------------------------------------
module cadj_levels
    import cadj_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        accept,
    input  logic        command,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic [15:0] pixel_rgb565,
    output logic        out_valid,
    output rgb_t        out_rgb
);

    logic [7:0] mem_r [256];
    logic [7:0] mem_g [256];
    logic [7:0] mem_b [256];
    logic [255:0] written_reg;

    logic [7:0] idx_r, idx_g, idx_b;
    logic [7:0] idx_r_reg, idx_g_reg, idx_b_reg;
    logic [7:0] rd_r_reg, rd_g_reg, rd_b_reg;
    logic       hit_r_reg, hit_g_reg, hit_b_reg;
    logic       valid_reg;
    logic       wr;

    // bit replication to 8 bits
    assign idx_r = {pixel_rgb565[15:11], pixel_rgb565[15:13]};
    assign idx_g = {pixel_rgb565[10:5], pixel_rgb565[10:9]};
    assign idx_b = {pixel_rgb565[4:0], pixel_rgb565[4:2]};
    assign wr    = accept && (command == CMD_TABLE_WRITE);

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_r[table_index] <= table_value;
            mem_g[table_index] <= table_value;
            mem_b[table_index] <= table_value;
        end
        if (en) begin
            rd_r_reg  <= mem_r[idx_r];
            rd_g_reg  <= mem_g[idx_g];
            rd_b_reg  <= mem_b[idx_b];
            hit_r_reg <= written_reg[idx_r];
            hit_g_reg <= written_reg[idx_g];
            hit_b_reg <= written_reg[idx_b];
            idx_r_reg <= idx_r;
            idx_g_reg <= idx_g;
            idx_b_reg <= idx_b;
        end
    end

    // unwritten entries read as identity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (wr) begin
                written_reg[table_index] <= 1'b1;
            end
            if (en) begin
                valid_reg <= accept && (command == CMD_PIXEL);
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_rgb.r = hit_r_reg ? rd_r_reg : idx_r_reg;
    assign out_rgb.g = hit_g_reg ? rd_g_reg : idx_g_reg;
    assign out_rgb.b = hit_b_reg ? rd_b_reg : idx_b_reg;

endmodule

// File: hdl/cadj_hsl.sv
// ----------------------------------------------------------------------------
// cadj_hsl
// saturation adjust through q16 hsl, bypassed at unity gain
// ----------------------------------------------------------------------------
module cadj_hsl
    import cadj_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  rgb_t        in_rgb,
    input  logic [10:0] saturation_factor,
    output logic        out_valid,
    output rgb_t        out_rgb
);

    localparam logic [1:0] SEL_P    = 2'd0;
    localparam logic [1:0] SEL_Q    = 2'd1;
    localparam logic [1:0] SEL_RAMP = 2'd2;

    typedef struct packed {
        logic        bypass;
        rgb_t        rgb;
        logic        neg;
        logic [2:0]  base;
        logic [16:0] l;
    } side_t;

    // ---- front: max, min, divider operands
    logic [7:0] r, g, b, mx, mn, d, ax;
    logic [8:0] sum, den, dv_h;
    logic [15:0] l_y;
    logic [16:0] l_adj;
    logic signed [8:0] x;
    logic redmax, grnmax, gray;
    side_t side_in;

    always_comb begin
        r = in_rgb.r;
        g = in_rgb.g;
        b = in_rgb.b;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum    = {1'b0, mx} + {1'b0, mn};
        d      = mx - mn;
        gray   = (mx == mn);
        redmax = (mx == r);
        grnmax = !redmax && (mx == g);
        if (redmax) begin
            x = $signed({1'b0, g}) - $signed({1'b0, b});
            side_in.base = (g < b) ? 3'd6 : 3'd0;
        end else if (grnmax) begin
            x = $signed({1'b0, b}) - $signed({1'b0, r});
            side_in.base = 3'd2;
        end else begin
            x = $signed({1'b0, r}) - $signed({1'b0, g});
            side_in.base = 3'd4;
        end
        side_in.neg    = x[8];
        ax             = x[8] ? 8'(-x) : x[7:0];
        side_in.bypass = (saturation_factor == SAT_UNITY);
        side_in.rgb    = in_rgb;
        // lightness sum*65536/510 = 128*sum + floor(128*sum/255)
        l_y        = {sum, 7'd0};
        l_adj      = 17'({1'b0, l_y} + {9'd0, l_y[15:8]} + 17'd1);
        side_in.l  = {1'b0, l_y} + {8'd0, l_adj[16:8]};
        den  = (sum > 9'd255) ? 9'(9'd510 - sum) : sum;
        if (den == 9'd0) den = 9'd1;
        dv_h = gray ? 9'd1 : {1'b0, d};
    end

    logic [QB-1:0] s_q, h_q;

    cadj_div u_div_s (
        .aclk(aclk), .en(en), .num({1'b0, d}), .den(den), .quo(s_q)
    );
    cadj_div u_div_h (
        .aclk(aclk), .en(en), .num({1'b0, ax}), .den(dv_h), .quo(h_q)
    );

    side_t side_reg [QB];
    logic  dvld_reg [QB];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < QB; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---- h1: hue, scaled saturation
    logic [19:0] base_q16, hs_w;
    logic [38:0] h_prod;
    logic [27:0] s_prod;
    logic [19:0] s_scaled;
    logic [16:0] h1_h_reg, h1_s_reg, h1_l_reg;
    side_t       h1_side_reg;

    always_comb begin
        base_q16 = {1'b0, side_reg[QB-1].base, 16'd0};
        hs_w     = side_reg[QB-1].neg ? 20'(base_q16 - {3'd0, h_q})
                                      : 20'(base_q16 + {3'd0, h_q});
        h_prod   = {20'd0, hs_w[18:0]} * {19'd0, DIV6_MUL};
        s_prod   = {11'd0, s_q} * {17'd0, saturation_factor};
        s_scaled = s_prod[27:8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_h_reg    <= h_prod[38:22];
            h1_s_reg    <= (s_scaled > {3'd0, Q16_ONE}) ? Q16_ONE : s_scaled[16:0];
            h1_l_reg    <= side_reg[QB-1].l;
            h1_side_reg <= side_reg[QB-1];
        end
    end

    // ---- h2: hue per channel, lightness product
    logic [17:0] tr_w, bop;
    logic [16:0] tb_w;
    logic [34:0] q_prod;
    logic [16:0] h2_tr_reg, h2_tg_reg, h2_tb_reg, h2_l_reg, h2_s_reg;
    logic [34:0] h2_prod_reg;
    logic        h2_zero_reg;
    side_t       h2_side_reg;

    always_comb begin
        tr_w = {1'b0, h1_h_reg} + {1'b0, HUE_THIRD};
        if (tr_w > {1'b0, Q16_ONE}) tr_w = 18'(tr_w - {1'b0, Q16_ONE});
        tb_w = (h1_h_reg >= HUE_THIRD) ? 17'(h1_h_reg - HUE_THIRD)
                                       : 17'(h1_h_reg + Q16_ONE - HUE_THIRD);
        bop  = (h1_l_reg < HUE_HALF) ? 18'({1'b0, Q16_ONE} + {1'b0, h1_s_reg})
                                     : {1'b0, h1_s_reg};
        q_prod = {18'd0, h1_l_reg} * {17'd0, bop};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h2_tr_reg   <= tr_w[16:0];
            h2_tg_reg   <= h1_h_reg;
            h2_tb_reg   <= tb_w;
            h2_l_reg    <= h1_l_reg;
            h2_s_reg    <= h1_s_reg;
            h2_prod_reg <= q_prod;
            h2_zero_reg <= (h1_s_reg == 17'd0);
            h2_side_reg <= h1_side_reg;
        end
    end

    // ---- h3: q, p and per-channel ramp factor
    logic [18:0] phi, q_u;
    logic signed [19:0] q_s, p_s;
    logic [16:0] t_ch [3];
    logic [16:0] f_ch [3];
    logic [1:0]  sel_ch [3];
    logic signed [19:0] h3_q_reg, h3_p_reg, h3_diff_reg;
    logic [16:0] h3_f_reg [3];
    logic [1:0]  h3_sel_reg [3];
    logic [16:0] h3_l_reg;
    logic        h3_zero_reg;
    side_t       h3_side_reg;

    always_comb begin
        phi = h2_prod_reg[34:16];
        q_u = (h2_l_reg < HUE_HALF) ? phi
                                    : 19'({2'b0, h2_l_reg} + {2'b0, h2_s_reg} - phi);
        q_s = $signed({1'b0, q_u});
        p_s = $signed({2'b0, h2_l_reg, 1'b0}) - q_s;
        t_ch[0] = h2_tr_reg;
        t_ch[1] = h2_tg_reg;
        t_ch[2] = h2_tb_reg;
        for (int i = 0; i < 3; i++) begin
            f_ch[i] = '0;
            if (t_ch[i] < HUE_SIXTH) begin
                sel_ch[i] = SEL_RAMP;
                f_ch[i]   = 17'({t_ch[i], 2'b0} + {1'b0, t_ch[i], 1'b0});
            end else if (t_ch[i] < HUE_HALF) begin
                sel_ch[i] = SEL_Q;
            end else if (t_ch[i] < HUE_TWO_THIRDS) begin
                sel_ch[i] = SEL_RAMP;
                f_ch[i]   = 17'(({HUE_TWO_THIRDS - t_ch[i], 2'b0})
                                + {1'b0, 17'(HUE_TWO_THIRDS - t_ch[i]), 1'b0});
            end else begin
                sel_ch[i] = SEL_P;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h3_q_reg    <= q_s;
            h3_p_reg    <= p_s;
            h3_diff_reg <= q_s - p_s;
            for (int i = 0; i < 3; i++) begin
                h3_f_reg[i]   <= f_ch[i];
                h3_sel_reg[i] <= sel_ch[i];
            end
            h3_l_reg    <= h2_l_reg;
            h3_zero_reg <= h2_zero_reg;
            h3_side_reg <= h2_side_reg;
        end
    end

    // ---- h4: ramp products, one multiplier per channel
    logic signed [37:0] h4_prod_reg [3];
    logic [1:0]  h4_sel_reg [3];
    logic signed [19:0] h4_q_reg, h4_p_reg;
    logic [16:0] h4_l_reg;
    logic        h4_zero_reg;
    side_t       h4_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                h4_prod_reg[i] <= 38'(h3_diff_reg * $signed({1'b0, h3_f_reg[i]}));
                h4_sel_reg[i]  <= h3_sel_reg[i];
            end
            h4_q_reg    <= h3_q_reg;
            h4_p_reg    <= h3_p_reg;
            h4_l_reg    <= h3_l_reg;
            h4_zero_reg <= h3_zero_reg;
            h4_side_reg <= h3_side_reg;
        end
    end

    // ---- h5: channel value in q16
    logic signed [21:0] c_ch [3];
    logic signed [21:0] h5_c_reg [3];
    side_t       h5_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (h4_sel_reg[i])
                SEL_RAMP: c_ch[i] = 22'(h4_p_reg) + h4_prod_reg[i][37:16];
                SEL_Q:    c_ch[i] = 22'(h4_q_reg);
                default:  c_ch[i] = 22'(h4_p_reg);
            endcase
            if (h4_zero_reg) c_ch[i] = $signed({5'd0, h4_l_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                h5_c_reg[i] <= c_ch[i];
            end
            h5_side_reg <= h4_side_reg;
        end
    end

    // ---- h6: back to bytes, bypass select
    logic [16:0] cc [3];
    logic [24:0] scaled [3];
    rgb_t        conv, h6_rgb_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (h5_c_reg[i] < 0) begin
                cc[i] = '0;
            end else if (h5_c_reg[i] > $signed({5'd0, Q16_ONE})) begin
                cc[i] = Q16_ONE;
            end else begin
                cc[i] = h5_c_reg[i][16:0];
            end
            scaled[i] = 25'({cc[i], 8'd0} - {8'd0, cc[i]});
        end
        conv.r = scaled[0][23:16];
        conv.g = scaled[1][23:16];
        conv.b = scaled[2][23:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h6_rgb_reg <= h5_side_reg.bypass ? h5_side_reg.rgb : conv;
        end
    end

    // ---- valid bits
    logic h1_vld_reg, h2_vld_reg, h3_vld_reg, h4_vld_reg, h5_vld_reg, h6_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QB; k++) begin
                dvld_reg[k] <= 1'b0;
            end
            h1_vld_reg <= 1'b0;
            h2_vld_reg <= 1'b0;
            h3_vld_reg <= 1'b0;
            h4_vld_reg <= 1'b0;
            h5_vld_reg <= 1'b0;
            h6_vld_reg <= 1'b0;
        end else if (en) begin
            dvld_reg[0] <= in_valid;
            for (int k = 1; k < QB; k++) begin
                dvld_reg[k] <= dvld_reg[k-1];
            end
            h1_vld_reg <= dvld_reg[QB-1];
            h2_vld_reg <= h1_vld_reg;
            h3_vld_reg <= h2_vld_reg;
            h4_vld_reg <= h3_vld_reg;
            h5_vld_reg <= h4_vld_reg;
            h6_vld_reg <= h5_vld_reg;
        end
    end

    assign out_valid = h6_vld_reg;
    assign out_rgb   = h6_rgb_reg;

endmodule

// File: hdl/cadj_tone.sv
// ----------------------------------------------------------------------------
// cadj_tone
// contrast about mid-grey, then temperature and tint offsets
// ----------------------------------------------------------------------------
module cadj_tone
    import cadj_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  rgb_t              in_rgb,
    input  logic [10:0]       contrast_gain,
    input  logic signed [9:0] temperature,
    input  logic signed [9:0] tint,
    output logic              out_valid,
    output rgb_t              out_rgb
);

    logic [7:0] v_in [3];
    logic signed [22:0] n_ch [3];
    logic signed [22:0] t0_n_reg [3];
    logic [7:0] cl_ch [3];
    logic [7:0] t1_v_reg [3];
    logic signed [18:0] tx, kx, off [3], wsum [3];
    logic [7:0] wb_ch [3];
    rgb_t t2_rgb_reg;
    logic t0_vld_reg, t1_vld_reg, t2_vld_reg;

    assign v_in[0] = in_rgb.r;
    assign v_in[1] = in_rgb.g;
    assign v_in[2] = in_rgb.b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ch[i] = 23'(($signed({2'b0, v_in[i]}) - 10'sd128)
                          * $signed({1'b0, contrast_gain})) + 23'sd32896;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (t0_n_reg[i] <= 0) begin
                cl_ch[i] = 8'd0;
            end else if (t0_n_reg[i][22:8] > 15'd255) begin
                cl_ch[i] = 8'd255;
            end else begin
                cl_ch[i] = t0_n_reg[i][15:8];
            end
        end
    end

    // offsets in 1/256 units
    always_comb begin
        tx = {{9{temperature[9]}}, temperature};
        kx = {{9{tint[9]}}, tint};
        off[0] = tx * 19'sd60 + kx * 19'sd20;
        off[1] = -(kx * 19'sd40);
        off[2] = kx * 19'sd20 - tx * 19'sd60;
        for (int i = 0; i < 3; i++) begin
            wsum[i] = $signed({3'b0, t1_v_reg[i], 8'd0}) + off[i];
            if (wsum[i] < 0) begin
                wb_ch[i] = 8'd0;
            end else if (wsum[i][18:8] > 11'd255) begin
                wb_ch[i] = 8'd255;
            end else begin
                wb_ch[i] = wsum[i][15:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t0_n_reg[i] <= n_ch[i];
                t1_v_reg[i] <= cl_ch[i];
            end
            t2_rgb_reg <= '{r: wb_ch[0], g: wb_ch[1], b: wb_ch[2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
        end else if (en) begin
            t0_vld_reg <= in_valid;
            t1_vld_reg <= t0_vld_reg;
            t2_vld_reg <= t1_vld_reg;
        end
    end

    assign out_valid = t2_vld_reg;
    assign out_rgb   = t2_rgb_reg;

endmodule
